// ===== rtl/clns_pkg.sv =====
// package for the character lcd nibble sequencer
// request codes, register indexes, bus constants and the job word shared by all modules
// no dependencies
package clns_pkg;

    // request codes carried on s_tuser
    localparam logic [2:0] CMD_INIT       = 3'd0;
    localparam logic [2:0] CMD_WRITE_CMD  = 3'd1;
    localparam logic [2:0] CMD_WRITE_DATA = 3'd2;
    localparam logic [2:0] CMD_SET_CURSOR = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;
    localparam logic [2:0] CMD_HOME       = 3'd5;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_FUNCTION_SET   = 2'd0;
    localparam logic [1:0] REG_DISPLAY_CONTROL = 2'd1;
    localparam logic [1:0] REG_ENTRY_MODE     = 2'd2;

    localparam logic [7:0] FUNCTION_SET_RESET    = 8'h28;
    localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'h0E;
    localparam logic [7:0] ENTRY_MODE_RESET      = 8'h06;

    // fixed lcd command bytes
    localparam logic [7:0] BYTE_WAKE_8BIT = 8'h33;
    localparam logic [7:0] BYTE_WAKE_4BIT = 8'h32;
    localparam logic [7:0] BYTE_CLEAR     = 8'h01;
    localparam logic [7:0] BYTE_HOME      = 8'h02;
    localparam logic [7:0] DDRAM_ROW1     = 8'h80;
    localparam logic [7:0] DDRAM_ROW2     = 8'hC0;

    localparam logic [1:0] ROW_FIRST  = 2'd1;
    localparam logic [1:0] ROW_SECOND = 2'd2;
    localparam logic [5:0] COL_MIN    = 6'd1;
    localparam logic [5:0] COL_MAX    = 6'd40;

    // hold times in ms
    localparam logic [5:0] HOLD_NONE   = 6'd0;
    localparam logic [5:0] HOLD_STROBE = 6'd1;
    localparam logic [5:0] HOLD_SHORT  = 6'd2;
    localparam logic [5:0] HOLD_STEP   = 6'd5;
    localparam logic [5:0] HOLD_POWER  = 6'd40;

    // init byte steps after the power-up wait
    localparam logic [2:0] STEP_WAKE_8BIT   = 3'd0;
    localparam logic [2:0] STEP_WAKE_4BIT   = 3'd1;
    localparam logic [2:0] STEP_FUNCTION    = 3'd2;
    localparam logic [2:0] STEP_CLEAR       = 3'd3;
    localparam logic [2:0] STEP_DISPLAY     = 3'd4;
    localparam logic [2:0] STEP_ENTRY       = 3'd5;

    // nibble phases of one byte
    localparam logic [1:0] PHASE_LAST = 2'd3;

    typedef struct packed {
        logic [7:0] function_set;
        logic [7:0] display_control;
        logic [7:0] entry_mode;
    } cfg_t;

    // one unit of work for the back end: a byte or the all-low power-up wait
    typedef struct packed {
        logic       is_wait;
        logic       rs;
        logic [7:0] data;
        logic [5:0] tail_hold;
        logic       last;
    } job_t;

endpackage

// ===== rtl/clns_front.sv =====
// front end: accepts requests and turns each into byte jobs for the queue
// uses clns_pkg; init is stepped out one job per cycle while the queue has room
module clns_front
    import clns_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [2:0] command,
    input  logic [7:0] byte_value,
    input  logic [1:0] row,
    input  logic [5:0] column,
    input  cfg_t       cfg,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    typedef enum logic {FR_IDLE, FR_INIT} state_t;

    state_t     state_reg;
    logic [2:0] step_reg;
    logic       accept;
    logic [5:0] col_sat;
    logic [5:0] col_addr;
    logic [7:0] cursor_byte;

    always_comb begin
        if (column < COL_MIN) begin
            col_sat = COL_MIN;
        end else if (column > COL_MAX) begin
            col_sat = COL_MAX;
        end else begin
            col_sat = column;
        end
        col_addr    = col_sat - COL_MIN;
        cursor_byte = ((row == ROW_FIRST) ? DDRAM_ROW1 : DDRAM_ROW2) | {2'b00, col_addr};
    end

    assign s_tready = (state_reg == FR_IDLE) && !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        push     = 1'b0;
        push_job = '0;
        unique case (state_reg)
            FR_IDLE: begin
                if (accept) begin
                    case (command)
                        CMD_INIT: begin
                            push              = 1'b1;
                            push_job.is_wait  = 1'b1;
                            push_job.tail_hold = HOLD_POWER;
                        end
                        CMD_WRITE_CMD, CMD_WRITE_DATA: begin
                            push               = 1'b1;
                            push_job.rs        = (command == CMD_WRITE_DATA);
                            push_job.data      = byte_value;
                            push_job.tail_hold = HOLD_NONE;
                            push_job.last      = 1'b1;
                        end
                        CMD_SET_CURSOR: begin
                            // rows other than one and two give nothing
                            push               = (row == ROW_FIRST) || (row == ROW_SECOND);
                            push_job.data      = cursor_byte;
                            push_job.tail_hold = HOLD_NONE;
                            push_job.last      = 1'b1;
                        end
                        CMD_CLEAR, CMD_HOME: begin
                            push               = 1'b1;
                            push_job.data      = (command == CMD_CLEAR) ? BYTE_CLEAR : BYTE_HOME;
                            push_job.tail_hold = HOLD_SHORT;
                            push_job.last      = 1'b1;
                        end
                        default: begin
                            push = 1'b0;
                        end
                    endcase
                end
            end
            FR_INIT: begin
                push               = !q_full;
                push_job.tail_hold = HOLD_STEP;
                push_job.last      = (step_reg == STEP_ENTRY);
                unique case (step_reg)
                    STEP_WAKE_8BIT: begin
                        push_job.data      = BYTE_WAKE_8BIT;
                        push_job.tail_hold = HOLD_NONE;
                    end
                    STEP_WAKE_4BIT: push_job.data = BYTE_WAKE_4BIT;
                    STEP_FUNCTION:  push_job.data = cfg.function_set;
                    STEP_CLEAR:     push_job.data = BYTE_CLEAR;
                    STEP_DISPLAY:   push_job.data = cfg.display_control;
                    default:        push_job.data = cfg.entry_mode;
                endcase
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            step_reg  <= STEP_WAKE_8BIT;
        end else begin
            unique case (state_reg)
                FR_IDLE: begin
                    if (accept && command == CMD_INIT) begin
                        state_reg <= FR_INIT;
                        step_reg  <= STEP_WAKE_8BIT;
                    end
                end
                FR_INIT: begin
                    if (!q_full) begin
                        if (step_reg == STEP_ENTRY) begin
                            state_reg <= FR_IDLE;
                        end else begin
                            step_reg <= step_reg + 3'd1;
                        end
                    end
                end
                default: state_reg <= FR_IDLE;
            endcase
        end
    end

    // never push into a full queue
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full) else $error("front pushed into full queue");

    // init steps stay within the six bytes
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FR_INIT |-> step_reg <= STEP_ENTRY) else $error("init step out of range");

endmodule

// ===== rtl/clns_queue.sv =====
// job queue between front and back end
// uses clns_pkg for job_t; flop storage read at the head only
module clns_queue
    import clns_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH)) else $error("queue count over depth");

endmodule

// ===== rtl/clns_back.sv =====
// back end: expands each job into pin events into an output register, one per cycle
// unless m_tready stalls it; uses clns_pkg; a byte is four events, the power-up wait one
module clns_back
    import clns_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       head_job,
    input  logic       q_empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       reg_select,
    output logic [3:0] nibble,
    output logic       enable,
    output logic [5:0] hold_ms,
    output logic       last
);

    job_t       job_reg;
    logic       job_valid_reg;
    logic [1:0] phase_reg;
    logic       out_valid_reg;
    logic       rs_reg;
    logic [3:0] nibble_reg;
    logic       enable_reg;
    logic [5:0] hold_reg;
    logic       last_reg;

    logic       out_free;
    logic       emit;
    logic       job_done;
    logic       load;
    logic       rs_next;
    logic [3:0] nibble_next;
    logic       enable_next;
    logic [5:0] hold_next;
    logic       last_next;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = job_valid_reg && out_free;
    assign job_done = emit && (job_reg.is_wait || phase_reg == PHASE_LAST);
    assign load     = (!job_valid_reg || job_done) && !q_empty;
    assign pop      = load;

    // phase bit 1 picks the low nibble, bit 0 is the enable-low half
    always_comb begin
        rs_next = job_reg.rs;
        if (job_reg.is_wait) begin
            nibble_next = 4'h0;
            enable_next = 1'b0;
            hold_next   = job_reg.tail_hold;
            last_next   = 1'b0;
        end else begin
            nibble_next = phase_reg[1] ? job_reg.data[3:0] : job_reg.data[7:4];
            enable_next = !phase_reg[0];
            if (!phase_reg[0]) begin
                hold_next = HOLD_STROBE;
            end else if (phase_reg[1]) begin
                hold_next = job_reg.tail_hold;
            end else begin
                hold_next = HOLD_NONE;
            end
            last_next = job_reg.last && (phase_reg == PHASE_LAST);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= head_job;
        end
        if (out_free && emit) begin
            rs_reg     <= rs_next;
            nibble_reg <= nibble_next;
            enable_reg <= enable_next;
            hold_reg   <= hold_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                job_valid_reg <= 1'b1;
                phase_reg     <= '0;
            end else if (job_done) begin
                job_valid_reg <= 1'b0;
                phase_reg     <= '0;
            end else if (emit) begin
                phase_reg <= phase_reg + 2'd1;
            end
            if (out_free) begin
                out_valid_reg <= emit;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign reg_select = rs_reg;
    assign nibble     = nibble_reg;
    assign enable     = enable_reg;
    assign hold_ms    = hold_reg;
    assign last       = last_reg;

    // a run always ends on an enable-low event
    a_last_low: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && last_reg |-> !enable_reg) else $error("last word with enable high");

    // a strobe-high event is always held one ms
    a_strobe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && enable_reg |-> hold_reg == HOLD_STROBE) else $error("bad strobe hold");

    // phase only moves while a job is held
    a_phase_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !job_valid_reg |-> phase_reg == '0) else $error("phase moved without a job");

endmodule

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// Four-bit character-LCD bus sequencer. Each request word on the s_ side yields a run of
// pin-event words on the m_ side (RS, D7..D4, enable level, hold time in ms, last mark):
// init gives 25 words, command/data/cursor/clear/home give 4, unused codes and cursor rows
// other than 1 and 2 give none. The back end issues one event word per cycle unless m_tready
// stalls the output register; the front end takes the next request once it has queued every
// byte of the current one and the job queue has room. Registers: 0x0 function set, 0x4
// display control, 0x8 entry mode.
// depends on clns_pkg, clns_front, clns_queue, clns_back
module char_lcd_nibble_sequencer
    import clns_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // byte_value[7:0], row[9:8], column[15:10]
    input  logic [2:0]  s_tuser,  // command[2:0]
    // pin event channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // nibble[3:0], enable[4], hold_ms[10:5], zero[15:11]
    output logic        m_tuser,  // reg_select
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg;
    logic       reg_write;
    logic [1:0] reg_index;

    logic       q_full;
    logic       q_empty;
    logic       push;
    logic       pop;
    job_t       push_job;
    job_t       head_job;

    logic [3:0] ev_nibble;
    logic       ev_enable;
    logic [5:0] ev_hold;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.function_set    <= FUNCTION_SET_RESET;
            cfg_reg.display_control <= DISPLAY_CONTROL_RESET;
            cfg_reg.entry_mode      <= ENTRY_MODE_RESET;
        end else if (reg_write) begin
            case (reg_index)
                REG_FUNCTION_SET:    cfg_reg.function_set    <= pwdata[7:0];
                REG_DISPLAY_CONTROL: cfg_reg.display_control <= pwdata[7:0];
                REG_ENTRY_MODE:      cfg_reg.entry_mode      <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_FUNCTION_SET:    prdata = {24'h0, cfg_reg.function_set};
            REG_DISPLAY_CONTROL: prdata = {24'h0, cfg_reg.display_control};
            REG_ENTRY_MODE:      prdata = {24'h0, cfg_reg.entry_mode};
            default:             prdata = 32'h0;
        endcase
    end

    clns_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .command    (s_tuser),
        .byte_value (s_tdata[7:0]),
        .row        (s_tdata[9:8]),
        .column     (s_tdata[15:10]),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    clns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    clns_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_job   (head_job),
        .q_empty    (q_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .reg_select (m_tuser),
        .nibble     (ev_nibble),
        .enable     (ev_enable),
        .hold_ms    (ev_hold),
        .last       (m_tlast)
    );

    assign m_tdata = {5'b00000, ev_hold, ev_enable, ev_nibble};

endmodule

// ===== test/tb_top.sv =====
// testbench for char_lcd_nibble_sequencer: request words in, predicted pin-event words checked out
// predicts each run of pin events from its own copy of the three init registers
// depends on clns_pkg and the char_lcd_nibble_sequencer rtl
module tb_top;
    import clns_pkg::*;

    // request codes the block ignores
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    // register index past the last one
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int TARGET_REQUESTS = 400;
    localparam int PHASE_REQUESTS = 60;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_CYCLES = 400;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] value;
        logic [1:0] row;
        logic [5:0] col;
    } lcd_req_t;

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic       en;
        logic [5:0] hold_ms;
        logic       last;
    } pin_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lcd_req_t   requests_to_send[$];
    pin_event_t pin_events_due[$];
    lcd_req_t   req_on_bus;

    logic [7:0] cfg_function_set = FUNCTION_SET_RESET;
    logic [7:0] cfg_display_control = DISPLAY_CONTROL_RESET;
    logic [7:0] cfg_entry_mode = ENTRY_MODE_RESET;

    logic burst_mode = 1'b0;
    int   stall_requests = 0;
    int   stall_served = 0;
    int   hold_left = 0;
    int   err_count = 0;

    char_lcd_nibble_sequencer u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 aclk = ~aclk;

    // ---------------- pin event prediction ----------------

    task automatic add_pin_event(input logic rs, input logic [3:0] nib, input logic en,
                                 input logic [5:0] hold);
        pin_event_t ev;
        ev.rs = rs;
        ev.nibble = nib;
        ev.en = en;
        ev.hold_ms = hold;
        ev.last = 1'b0;
        pin_events_due.push_back(ev);
    endtask

    // high nibble first, each nibble strobed high for 1 ms then dropped
    task automatic add_lcd_byte(input logic rs, input logic [7:0] b, input logic [5:0] tail);
        add_pin_event(rs, b[7:4], 1'b1, HOLD_STROBE);
        add_pin_event(rs, b[7:4], 1'b0, HOLD_NONE);
        add_pin_event(rs, b[3:0], 1'b1, HOLD_STROBE);
        add_pin_event(rs, b[3:0], 1'b0, tail);
    endtask

    task automatic predict_pin_events(input lcd_req_t req);
        int n_prior;
        logic [5:0] col;
        n_prior = pin_events_due.size();
        col = req.col;
        if (col < COL_MIN) col = COL_MIN;
        if (col > COL_MAX) col = COL_MAX;
        case (req.cmd)
            CMD_INIT: begin
                add_pin_event(1'b0, 4'h0, 1'b0, HOLD_POWER);
                add_lcd_byte(1'b0, BYTE_WAKE_8BIT, HOLD_NONE);
                add_lcd_byte(1'b0, BYTE_WAKE_4BIT, HOLD_STEP);
                add_lcd_byte(1'b0, cfg_function_set, HOLD_STEP);
                add_lcd_byte(1'b0, BYTE_CLEAR, HOLD_STEP);
                add_lcd_byte(1'b0, cfg_display_control, HOLD_STEP);
                add_lcd_byte(1'b0, cfg_entry_mode, HOLD_STEP);
            end
            CMD_WRITE_CMD: add_lcd_byte(1'b0, req.value, HOLD_NONE);
            CMD_WRITE_DATA: add_lcd_byte(1'b1, req.value, HOLD_NONE);
            CMD_SET_CURSOR: begin
                if (req.row == ROW_FIRST) begin
                    add_lcd_byte(1'b0, {2'b00, col - 6'd1} | DDRAM_ROW1, HOLD_NONE);
                end else if (req.row == ROW_SECOND) begin
                    add_lcd_byte(1'b0, {2'b00, col - 6'd1} | DDRAM_ROW2, HOLD_NONE);
                end
            end
            CMD_CLEAR: add_lcd_byte(1'b0, BYTE_CLEAR, HOLD_SHORT);
            CMD_HOME: add_lcd_byte(1'b0, BYTE_HOME, HOLD_SHORT);
            default: ;
        endcase
        if (pin_events_due.size() > n_prior) begin
            pin_events_due[pin_events_due.size() - 1].last = 1'b1;
        end
    endtask

    function automatic lcd_req_t random_request();
        lcd_req_t req;
        int pick;
        pick = $urandom_range(99);
        req.value = 8'($urandom);
        req.row = 2'($urandom);
        req.col = ($urandom_range(99) < 85) ? 6'($urandom_range(40, 1))
                                            : 6'($urandom_range(63));
        if (pick < 8) req.cmd = CMD_INIT;
        else if (pick < 30) req.cmd = CMD_WRITE_CMD;
        else if (pick < 55) req.cmd = CMD_WRITE_DATA;
        else if (pick < 80) req.cmd = CMD_SET_CURSOR;
        else if (pick < 87) req.cmd = CMD_CLEAR;
        else if (pick < 94) req.cmd = CMD_HOME;
        else req.cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
        // mostly valid rows for cursor moves
        if (req.cmd == CMD_SET_CURSOR && $urandom_range(99) < 85) begin
            req.row = $urandom_range(1) ? ROW_FIRST : ROW_SECOND;
        end
        return req;
    endfunction

    // ---------------- request driver ----------------

    always @(posedge aclk) begin
        logic offer;
        offer = s_tvalid;
        if (!aresetn) begin
            offer = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pin_events(req_on_bus);
                offer = 1'b0;
            end
            if (!offer && requests_to_send.size() > 0
                && (burst_mode || $urandom_range(99) >= 10)) begin
                req_on_bus = requests_to_send.pop_front();
                s_tdata <= {req_on_bus.col, req_on_bus.row, req_on_bus.value};
                s_tuser <= req_on_bus.cmd;
                offer = 1'b1;
            end
        end
        s_tvalid <= offer;
    end

    // ---------------- result side: ready and checker ----------------

    always @(posedge aclk) begin
        if (stall_served != stall_requests) begin
            stall_served++;
            hold_left = STALL_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= burst_mode || ($urandom_range(99) >= 10);
        end
    end

    task automatic note_mismatch(input string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endtask

    always @(posedge aclk) begin
        pin_event_t got;
        pin_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rs = m_tuser;
            got.nibble = m_tdata[3:0];
            got.en = m_tdata[4];
            got.hold_ms = m_tdata[10:5];
            got.last = m_tlast;
            if (pin_events_due.size() == 0) begin
                note_mismatch($sformatf("unexpected word: rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                    got.rs, got.nibble, got.en, got.hold_ms, got.last));
            end else begin
                want = pin_events_due.pop_front();
                if (got !== want || m_tdata[15:11] !== 5'd0) begin
                    note_mismatch($sformatf({"word mismatch: exp rs=%0d nib=%h en=%0d ",
                        "hold=%0d last=%0d, got rs=%0d nib=%h en=%0d hold=%0d last=%0d pad=%h"},
                        want.rs, want.nibble, want.en, want.hold_ms, want.last,
                        got.rs, got.nibble, got.en, got.hold_ms, got.last, m_tdata[15:11]));
                end
            end
        end
    end

    // ---------------- sequence ----------------

    task automatic queue_request(input logic [2:0] cmd, input logic [7:0] value,
                                 input logic [1:0] row, input logic [5:0] col);
        lcd_req_t req;
        req.cmd = cmd;
        req.value = value;
        req.row = row;
        req.col = col;
        requests_to_send.push_back(req);
    endtask

    // wait for the sender and the expected store to empty, then let the block go quiet
    task automatic settle();
        do @(negedge aclk);
        while (requests_to_send.size() > 0 || s_tvalid || pin_events_due.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom_range(32'hFF_FFFF)), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FUNCTION_SET: cfg_function_set = value;
            REG_DISPLAY_CONTROL: cfg_display_control = value;
            REG_ENTRY_MODE: cfg_entry_mode = value;
            default: ;
        endcase
    endtask

    task automatic write_all_registers(input logic [7:0] fs, input logic [7:0] dc,
                                       input logic [7:0] em);
        write_register(REG_FUNCTION_SET, fs);
        write_register(REG_DISPLAY_CONTROL, dc);
        write_register(REG_ENTRY_MODE, em);
    endtask

    initial begin
        int counted;
        int phase;
        lcd_req_t req;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part with reset register values
        @(negedge aclk);
        queue_request(CMD_INIT, 8'h00, 2'd0, 6'd1);
        queue_request(CMD_WRITE_CMD, 8'h00, 2'd0, 6'd1);
        queue_request(CMD_WRITE_CMD, 8'hFF, 2'd3, 6'd63);
        queue_request(CMD_WRITE_DATA, 8'h00, 2'd0, 6'd0);
        queue_request(CMD_WRITE_DATA, 8'hFF, 2'd3, 6'd63);
        queue_request(CMD_WRITE_DATA, 8'hA5, 2'd1, 6'd20);
        queue_request(CMD_SET_CURSOR, 8'h00, ROW_FIRST, 6'd1);
        queue_request(CMD_SET_CURSOR, 8'hFF, ROW_FIRST, 6'd40);
        queue_request(CMD_SET_CURSOR, 8'h00, ROW_SECOND, 6'd1);
        queue_request(CMD_SET_CURSOR, 8'h00, ROW_SECOND, 6'd40);
        // column saturation at both ends
        queue_request(CMD_SET_CURSOR, 8'h00, ROW_SECOND, 6'd0);
        queue_request(CMD_SET_CURSOR, 8'h00, ROW_FIRST, 6'd41);
        queue_request(CMD_SET_CURSOR, 8'h00, ROW_FIRST, 6'd63);
        // rows that move nothing
        queue_request(CMD_SET_CURSOR, 8'h00, 2'd0, 6'd5);
        queue_request(CMD_SET_CURSOR, 8'h00, 2'd3, 6'd5);
        queue_request(CMD_CLEAR, 8'h00, 2'd0, 6'd1);
        queue_request(CMD_HOME, 8'h00, 2'd0, 6'd1);
        queue_request(CMD_SPARE_A, 8'hFF, ROW_FIRST, 6'd1);
        queue_request(CMD_SPARE_B, 8'h00, ROW_SECOND, 6'd1);
        settle();

        // register extremes, each checked through an init run
        write_all_registers(8'h00, 8'h00, 8'h00);
        @(negedge aclk);
        queue_request(CMD_INIT, 8'h00, 2'd0, 6'd1);
        settle();
        write_all_registers(8'hFF, 8'hFF, 8'hFF);
        @(negedge aclk);
        queue_request(CMD_INIT, 8'h00, 2'd0, 6'd1);
        settle();
        // write past the last register must leave the others alone
        write_register(REG_SPARE, 8'h5A);
        @(negedge aclk);
        queue_request(CMD_INIT, 8'h00, 2'd0, 6'd1);
        settle();

        // random phases, the first with reset register values, the rest with fresh random ones
        counted = 0;
        phase = 0;
        while (counted < TARGET_REQUESTS) begin
            if (phase == 0) begin
                write_all_registers(FUNCTION_SET_RESET, DISPLAY_CONTROL_RESET,
                                    ENTRY_MODE_RESET);
            end else begin
                write_all_registers(8'($urandom), 8'($urandom), 8'($urandom));
            end
            @(negedge aclk);
            burst_mode = (phase == 1);
            // long receiver hold-off while requests keep coming
            if (phase == 2) stall_requests++;
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                req = random_request();
                requests_to_send.push_back(req);
                counted++;
            end
            settle();
            burst_mode = 1'b0;
            phase++;
        end

        repeat (60) @(posedge aclk);
        if (err_count == 0 && pin_events_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
